// ===== src/tsp_pkg.sv =====
// Shared types, constants and codes for the trapezoid step-period generator.
package tsp_pkg;

  // Move limits and output divider of the step timer.
  localparam int unsigned MAX_STEPS  = 65535;
  localparam int unsigned TOGGLE_DIV = 2;

  // Datapath widths.
  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned FP_W    = 32;
  localparam int unsigned RATE_W  = 24;
  localparam int unsigned TOG_W   = $clog2(TOGGLE_DIV + 1);
  localparam int unsigned PDIV_W  = FREQ_W + TOG_W;
  localparam int unsigned DIV_W   = 24;
  localparam int unsigned DIV_N   = 32;
  localparam int unsigned DCNT_W  = $clog2(DIV_N);
  localparam int unsigned MUL_N   = 16;
  localparam int unsigned MCNT_W  = $clog2(MUL_N);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MAX_FREQ    = 3'd0,
    REG_ACCEL_RATE  = 3'd1,
    REG_START_FREQ  = 3'd2,
    REG_MIN_FREQ    = 3'd3,
    REG_CCR_MIN     = 3'd4,
    REG_CCR_MAX     = 3'd5,
    REG_TIMER_CLOCK = 3'd6
  } reg_idx_t;

  // Command codes.
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  // Phase codes of a result.
  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_NONE   = 2'd3
  } phase_t;

  // Status codes of a result.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_PARAM = 2'd1,
    STAT_NO_MOVE   = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LEN,
    ST_DIV_LEN,
    ST_PLAN,
    ST_DIV_DELTA,
    ST_MUL_TOP,
    ST_DIV_PER,
    ST_EMIT
  } state_t;

  // Command beat.
  typedef struct packed {
    logic        action;
    logic [15:0] steps;
  } cmd_t;

  // Result beat.
  typedef struct packed {
    logic [15:0] ccr;
    logic [1:0]  phase;
    logic        last;
    logic [1:0]  status;
    logic [15:0] accel_count;
    logic [15:0] cruise_count;
    logic [15:0] decel_count;
  } res_t;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [DIV_N-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_N-1:0]  quotient;
  } div_rsp_t;

  // Multiplier request and response.
  typedef struct packed {
    logic              start;
    logic [FP_W-1:0]   mcand;
    logic [MUL_N-1:0]  mplier;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [FP_W-1:0]   product;
  } mul_rsp_t;

endpackage

// ===== src/tsp_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module tsp_div import tsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_N-1:0]  quo;
  logic [DIV_N-1:0]  quo_next;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  rem_next;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    rem_sh;

  // One trial subtraction: the dividend shifts out of quo as quotient bits shift in.
  // A zero divisor always succeeds, so the quotient comes out all ones.
  always_comb begin
    rem_sh = {rem, quo[DIV_N-1]};
    if (rem_sh >= {1'b0, dvs}) begin
      rem_next = DIV_W'(rem_sh - {1'b0, dvs});
      quo_next = {quo[DIV_N-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[DIV_W-1:0];
      quo_next = {quo[DIV_N-2:0], 1'b0};
    end
  end

  // Control: iteration count and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== src/tsp_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle, low product word kept.
module tsp_mul import tsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [MCNT_W-1:0] cnt;
  logic [FP_W-1:0]   mcand;
  logic [MUL_N-1:0]  mplier;
  logic [FP_W-1:0]   prod;

  // Control: iteration count and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MCNT_W'(MUL_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Add the shifted multiplicand when the current multiplier bit is set.
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand  <= req.mcand;
      mplier <= req.mplier;
      prod   <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= {mcand[FP_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[MUL_N-1:1]};
    end
  end

  assign rsp.busy    = busy;
  assign rsp.done    = done;
  assign rsp.product = prod;

endmodule

// ===== src/trapezoid_step_period_generator.sv =====
// Top level of the trapezoid step-period generator: sequencer, move state and result register.
// A start beat gives its result after two multiplications and three divisions on the shared
// serial units, one after another. Ramp steps give theirs after one division; cruise steps and
// errors use neither unit.
// The next command is taken the cycle after a result is loaded; a stalled result holds the block.
// Synchronous reset loads the register defaults, clears the move and empties the result.
module trapezoid_step_period_generator import tsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers.
  logic [FREQ_W-1:0] max_freq;
  logic [RATE_W-1:0] accel_rate;
  logic [FREQ_W-1:0] base_freq;
  logic [FREQ_W-1:0] min_freq;
  logic [15:0]       ccr_min;
  logic [15:0]       ccr_max;
  logic [31:0]       timer_clock;

  // Move state.
  logic              move_active;
  logic [15:0]       step_index;
  logic [15:0]       accel_len;
  logic [15:0]       cruise_len;
  logic [15:0]       decel_len;
  logic [FP_W-1:0]   freq_accum;
  logic [FP_W-1:0]   freq_delta;
  logic [15:0]       cruise_period;
  logic [FREQ_W-1:0] plan_sf;
  logic [FREQ_W-1:0] plan_mf;
  logic [15:0]       total;
  logic [31:0]       len;
  logic              per_plan;

  state_t   state;
  state_t   state_next;
  res_t     pend;
  res_t     pend_next;
  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic cmd_acc;
  logic res_free;

  // Divisor of a period: whole hertz, floored at min_freq, times the toggle factor.
  function automatic logic [PDIV_W-1:0] period_divisor(input logic [FP_W-1:0] fp,
                                                       input logic [FREQ_W-1:0] fmin);
    logic [FREQ_W-1:0] f;
    f = fp[FP_W-1:FREQ_W];
    if (f < fmin) begin
      f = fmin;
    end
    return PDIV_W'(f) * PDIV_W'(TOGGLE_DIV);
  endfunction

  // Clamp a quotient to the compare limits, lower limit tested first.
  function automatic logic [15:0] clamp_ccr(input logic [31:0] q, input logic [15:0] lo,
                                            input logic [15:0] hi);
    logic [15:0] r;
    if (q < {16'd0, lo}) begin
      r = lo;
    end else if (q > {16'd0, hi}) begin
      r = hi;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != ST_IDLE);
  assign res_free  = !res_valid || !res_stall;
  assign cfg_ready = 1'b1;

  // Start command: parameter check and ramp frequencies.
  logic [FREQ_W-1:0] sf;
  logic [FREQ_W-1:0] mf;
  logic [FREQ_W:0]   fsum;
  logic              start_bad;

  always_comb begin
    sf        = (base_freq == 16'hFFFF) ? 16'hFFFE : base_freq;
    mf        = (max_freq <= sf) ? sf + 16'd1 : max_freq;
    fsum      = {1'b0, sf} + {1'b0, mf};
    start_bad = (cmd.steps == 16'd0) || ({8'd0, cmd.steps} > 24'(MAX_STEPS)) ||
                (max_freq < min_freq) || (accel_rate == '0);
  end

  // Step command: phase of the current step and the frequency it uses.
  logic [16:0]     ac_sum;
  logic [17:0]     tot_sum;
  logic [16:0]     idx;
  logic            in_accel;
  logic            in_cruise;
  logic            step_last;
  logic [FP_W-1:0] base_fp;
  logic [FP_W-1:0] step_src;

  always_comb begin
    ac_sum    = {1'b0, accel_len} + {1'b0, cruise_len};
    tot_sum   = {1'b0, ac_sum} + {2'd0, decel_len};
    idx       = {1'b0, step_index};
    in_accel  = idx < {1'b0, accel_len};
    in_cruise = !in_accel && (idx < ac_sum);
    step_last = ({1'b0, idx} + 18'd1) >= tot_sum;
    base_fp   = {plan_sf, 16'd0};
    if (!in_accel && (idx == ac_sum)) begin
      step_src = {plan_mf, 16'd0};
    end else begin
      step_src = freq_accum;
    end
  end

  // Plan: cap the ramp length, then split short moves evenly.
  logic [15:0] half;
  logic [15:0] lcap;
  logic [15:0] p_acc;
  logic [15:0] p_dec;
  logic [15:0] p_cru;
  logic [16:0] twice;

  always_comb begin
    half  = {1'b0, total[15:1]};
    lcap  = (len > {16'd0, half}) ? half : len[15:0];
    p_acc = (lcap == 16'd0) ? 16'd1 : lcap;
    twice = {p_acc, 1'b0};
    if (twice >= {1'b0, total}) begin
      p_acc = half;
      p_dec = total - half;
      p_cru = 16'd0;
    end else begin
      p_dec = p_acc;
      p_cru = 16'(({1'b0, total}) - twice);
    end
  end

  logic [FP_W-1:0] delta_val;
  logic [FP_W-1:0] top_src;
  logic [FP_W-1:0] per_src;

  assign delta_val = (accel_len == 16'd0) ? '0 : div_rsp.quotient;
  assign top_src   = base_fp + mul_rsp.product;
  assign per_src   = (state == ST_IDLE) ? step_src : top_src;

  // Sequencer: next state and requests to the shared units.
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = timer_clock;
    div_req.divisor  = DIV_W'(period_divisor(per_src, min_freq));
    mul_req.start    = 1'b0;
    mul_req.mcand    = {16'd0, mf - sf};
    mul_req.mplier   = fsum[16:1];
    unique case (state)
      ST_IDLE: begin
        if (cmd_acc) begin
          if (cmd.action == ACT_START) begin
            if (start_bad) begin
              state_next = ST_EMIT;
            end else begin
              mul_req.start = 1'b1;
              state_next    = ST_MUL_LEN;
            end
          end else if (!move_active || in_cruise) begin
            state_next = ST_EMIT;
          end else begin
            div_req.start = 1'b1;
            state_next    = ST_DIV_PER;
          end
        end
      end
      ST_MUL_LEN: begin
        if (mul_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_rsp.product;
          div_req.divisor  = accel_rate;
          state_next       = ST_DIV_LEN;
        end
      end
      ST_DIV_LEN: begin
        if (div_rsp.done) begin
          state_next = ST_PLAN;
        end
      end
      ST_PLAN: begin
        div_req.start    = 1'b1;
        div_req.dividend = {plan_mf - plan_sf, 16'd0};
        div_req.divisor  = DIV_W'(p_acc);
        state_next       = ST_DIV_DELTA;
      end
      ST_DIV_DELTA: begin
        if (div_rsp.done) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = delta_val;
          mul_req.mplier = accel_len;
          state_next     = ST_MUL_TOP;
        end
      end
      ST_MUL_TOP: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV_PER;
        end
      end
      ST_DIV_PER: begin
        if (div_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_freq    <= 16'd1000;
      accel_rate  <= 24'd10000;
      base_freq   <= 16'd100;
      min_freq    <= 16'd10;
      ccr_min     <= 16'd1;
      ccr_max     <= 16'd65535;
      timer_clock <= 32'd1000000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_FREQ:    max_freq    <= cfg_data[15:0];
        REG_ACCEL_RATE:  accel_rate  <= cfg_data[23:0];
        REG_START_FREQ:  base_freq   <= cfg_data[15:0];
        REG_MIN_FREQ:    min_freq    <= cfg_data[15:0];
        REG_CCR_MIN:     ccr_min     <= cfg_data[15:0];
        REG_CCR_MAX:     ccr_max     <= cfg_data[15:0];
        REG_TIMER_CLOCK: timer_clock <= cfg_data;
        default: ;
      endcase
    end
  end

  // Move state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      move_active   <= 1'b0;
      step_index    <= '0;
      accel_len     <= '0;
      cruise_len    <= '0;
      decel_len     <= '0;
      freq_accum    <= '0;
      freq_delta    <= '0;
      cruise_period <= '0;
      plan_sf       <= '0;
      plan_mf       <= '0;
      total         <= '0;
      len           <= '0;
      per_plan      <= 1'b0;
    end else begin
      if ((state == ST_IDLE) && cmd_acc) begin
        if (cmd.action == ACT_START) begin
          if (!start_bad) begin
            total    <= cmd.steps;
            plan_sf  <= sf;
            plan_mf  <= mf;
            per_plan <= 1'b1;
          end
        end else if (move_active) begin
          per_plan   <= 1'b0;
          step_index <= step_index + 16'd1;
          if (step_last) begin
            move_active <= 1'b0;
          end
          if (in_accel) begin
            freq_accum <= freq_accum + freq_delta;
          end else if (!in_cruise) begin
            if (step_src < base_fp + freq_delta) begin
              freq_accum <= base_fp;
            end else begin
              freq_accum <= step_src - freq_delta;
            end
          end
        end
      end
      if ((state == ST_DIV_LEN) && div_rsp.done) begin
        len <= div_rsp.quotient;
      end
      if (state == ST_PLAN) begin
        accel_len   <= p_acc;
        cruise_len  <= p_cru;
        decel_len   <= p_dec;
        step_index  <= '0;
        move_active <= 1'b1;
        freq_accum  <= base_fp;
      end
      if ((state == ST_DIV_DELTA) && div_rsp.done) begin
        freq_delta <= delta_val;
      end
      if ((state == ST_DIV_PER) && div_rsp.done && per_plan) begin
        cruise_period <= clamp_ccr(div_rsp.quotient, ccr_min, ccr_max);
      end
    end
  end

  // Pending beat, built as the command is worked.
  always_comb begin
    pend_next = pend;
    if ((state == ST_IDLE) && cmd_acc) begin
      pend_next = '{ccr: 16'd0, phase: PH_NONE, last: 1'b0, status: STAT_OK,
                    accel_count: 16'd0, cruise_count: 16'd0, decel_count: 16'd0};
      if (cmd.action == ACT_START) begin
        if (start_bad) begin
          pend_next.status = STAT_BAD_PARAM;
        end
      end else if (!move_active) begin
        pend_next.status = STAT_NO_MOVE;
      end else begin
        pend_next.last = step_last;
        if (in_accel) begin
          pend_next.phase = PH_ACCEL;
        end else if (in_cruise) begin
          pend_next.phase = PH_CRUISE;
          pend_next.ccr   = cruise_period;
        end else begin
          pend_next.phase = PH_DECEL;
        end
      end
    end
    if (state == ST_PLAN) begin
      pend_next.accel_count  = p_acc;
      pend_next.cruise_count = p_cru;
      pend_next.decel_count  = p_dec;
    end
    if ((state == ST_DIV_PER) && div_rsp.done && !per_plan) begin
      pend_next.ccr = clamp_ccr(div_rsp.quotient, ccr_min, ccr_max);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  // Result register: loaded from the pending beat once the previous beat has gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == ST_EMIT) && res_free) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && res_free) begin
      res <= pend;
    end
  end

  tsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tsp_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // The two serial units are never at work together.
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(div_rsp.busy && mul_rsp.busy))
    else $error("divider and multiplier busy together");

  // An accepted command holds off the next one.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |=> cmd_stall)
    else $error("second command accepted while one is in work");

  // An active move always has a step left.
  a_index_in_move: assert property (@(posedge clk) disable iff (rst)
    move_active |-> ({2'd0, step_index} < tot_sum))
    else $error("active move has run past its last step");

  // Divider results arrive only in states that wait for them.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV_LEN || state == ST_DIV_DELTA || state == ST_DIV_PER))
    else $error("divider result with no state waiting for it");

endmodule
